>>> hdl/bres_pkg.sv
// Shared types, constants and helper functions of the wrapped line rasterizer.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package bres_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 14;
  localparam int unsigned CFG_W           = 13;
  localparam int unsigned PIX_W           = 12;
  localparam int unsigned COLOR_W         = 32;
  localparam int unsigned OUT_TDATA_W     = 2 * PIX_W + COLOR_W;

  localparam logic [CFG_W-1:0] VIEW_MAX     = 13'd4096;
  localparam logic [CFG_W-1:0] VIEW_W_RESET = 13'd640;
  localparam logic [CFG_W-1:0] VIEW_H_RESET = 13'd480;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_VIEW_WIDTH  = 1'b0,
    REG_VIEW_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic load_line;
    logic emit;
    logic wrap_start;
  } ctrl_cmd_t;

  typedef struct packed {
    logic line_active;
    logic wrap_stale;
    logic wrap_done;
    logic out_free;
  } dp_status_t;

  // A size of zero acts as one, and anything above the maximum acts as the maximum.
  function automatic logic [CFG_W-1:0] view_size(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = {{(CFG_W-1){1'b0}}, 1'b1};
    end else if (v > VIEW_MAX) begin
      r = VIEW_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Moves a wrapped coordinate by one in either direction, or holds it.
  function automatic logic [PIX_W-1:0] wrap_step(input logic [PIX_W-1:0] cur,
                                                 input logic [CFG_W-1:0] size,
                                                 input logic inc,
                                                 input logic dec);
    logic [CFG_W-1:0] top;
    logic [PIX_W-1:0] r;
    top = size - {{(CFG_W-1){1'b0}}, 1'b1};
    if (inc) begin
      r = ({1'b0, cur} == top) ? '0 : cur + {{(PIX_W-1){1'b0}}, 1'b1};
    end else if (dec) begin
      r = (cur == '0) ? top[PIX_W-1:0] : cur - {{(PIX_W-1){1'b0}}, 1'b1};
    end else begin
      r = cur;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/bres_mod.sv
// Iterative floored modulo of a signed coordinate by the view size, one bit per cycle.
// Depends on bres_pkg.
`default_nettype none

module bres_mod #(
  parameter int unsigned CoordW = bres_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic signed [CoordW-1:0]       value_i,
  input  wire logic [bres_pkg::CFG_W-1:0]     size_i,
  output logic                                done_o,
  output logic [bres_pkg::PIX_W-1:0]          rem_o
);

  localparam int unsigned CntW = $clog2(CoordW + 1);

  logic                          busy_q;
  logic                          done_q;
  logic [CntW-1:0]               cnt_q;
  logic [CoordW-1:0]             mag_q;
  logic                          neg_q;
  logic [bres_pkg::PIX_W-1:0]    rem_q;
  logic [bres_pkg::PIX_W-1:0]    rem_d;
  logic [bres_pkg::CFG_W-1:0]    trial;
  logic [bres_pkg::CFG_W-1:0]    trial_sub;
  logic [bres_pkg::CFG_W-1:0]    flip;
  logic [CoordW-1:0]             mag_start;

  assign mag_start = value_i[CoordW-1] ? (~value_i + {{(CoordW-1){1'b0}}, 1'b1}) : value_i;
  assign trial     = {rem_q, mag_q[CoordW-1]};
  assign trial_sub = trial - size_i;
  assign rem_d     = (trial >= size_i) ? trial_sub[bres_pkg::PIX_W-1:0]
                                       : trial[bres_pkg::PIX_W-1:0];
  assign flip      = size_i - {1'b0, rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(CoordW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - {{(CntW-1){1'b0}}, 1'b1};
        if (cnt_q == {{(CntW-1){1'b0}}, 1'b1}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_start;
      neg_q <= value_i[CoordW-1];
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[CoordW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = (neg_q && (rem_q != '0)) ? flip[bres_pkg::PIX_W-1:0] : rem_q;

endmodule

`default_nettype wire

>>> hdl/bres_dp.sv
// Datapath of the line rasterizer: line state, decision term, wrapped pixel position,
// view registers and output register. Depends on bres_pkg and bres_mod.
`default_nettype none

module bres_dp #(
  parameter int unsigned CoordW = bres_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bres_pkg::ctrl_cmd_t              cmd_i,
  output bres_pkg::dp_status_t                  status_o,
  input  wire logic                             cfg_valid_i,
  input  wire logic                             cfg_index_i,
  input  wire logic [bres_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic signed [CoordW-1:0]         start_x_i,
  input  wire logic signed [CoordW-1:0]         start_y_i,
  input  wire logic signed [CoordW-1:0]         end_x_i,
  input  wire logic signed [CoordW-1:0]         end_y_i,
  input  wire logic [bres_pkg::COLOR_W-1:0]     line_color_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [bres_pkg::PIX_W-1:0]            pixel_x_o,
  output logic [bres_pkg::PIX_W-1:0]            pixel_y_o,
  output logic [bres_pkg::COLOR_W-1:0]          pixel_color_o,
  output logic                                  last_pixel_o
);

  localparam int unsigned DW = CoordW + 1;
  localparam int unsigned EW = CoordW + 3;

  logic [bres_pkg::CFG_W-1:0]   view_w_q, view_h_q, eff_w, eff_h;
  logic                         active_q, stale_q, steep_q, minor_neg_q;
  logic signed [CoordW-1:0]     major_q, end_q, minor_q;
  logic [CoordW-1:0]            majd_q, mind_q;
  logic signed [EW-1:0]         err_q;
  logic [bres_pkg::COLOR_W-1:0] color_q;
  logic [bres_pkg::PIX_W-1:0]   wx_q, wy_q, mod_x, mod_y;
  logic                         done_x, done_y;
  logic                         out_valid_q, out_last_q;
  logic [bres_pkg::PIX_W-1:0]   out_x_q, out_y_q;
  logic [bres_pkg::COLOR_W-1:0] out_color_q;

  // Start item setup.
  logic signed [DW-1:0]     dx, dy, ndx, ndy, dmaj, dmin, ndmin;
  logic [CoordW-1:0]        adx, ady, admin;
  logic                     steep_n, swap;
  logic signed [CoordW-1:0] a0, a1, b0, b1, maj_s, maj_e, min_s, min_e;
  logic signed [EW-1:0]     err0;

  // Step update.
  logic                     err_pos, minor_move, last;
  logic signed [EW-1:0]     inc_a, inc_b, err_next;
  logic signed [CoordW-1:0] raw_x, raw_y;
  logic signed [DW-1:0]     major_ext1, end_ext;
  logic                     x_inc, x_dec, y_inc, y_dec;

  assign eff_w = bres_pkg::view_size(view_w_q);
  assign eff_h = bres_pkg::view_size(view_h_q);

  always_comb begin
    dx      = $signed({end_x_i[CoordW-1], end_x_i}) - $signed({start_x_i[CoordW-1], start_x_i});
    dy      = $signed({end_y_i[CoordW-1], end_y_i}) - $signed({start_y_i[CoordW-1], start_y_i});
    ndx     = -dx;
    ndy     = -dy;
    adx     = dx[DW-1] ? ndx[CoordW-1:0] : dx[CoordW-1:0];
    ady     = dy[DW-1] ? ndy[CoordW-1:0] : dy[CoordW-1:0];
    steep_n = (ady >= adx);
    a0      = steep_n ? start_y_i : start_x_i;
    a1      = steep_n ? end_y_i   : end_x_i;
    b0      = steep_n ? start_x_i : start_y_i;
    b1      = steep_n ? end_x_i   : end_y_i;
    swap    = (a0 > a1);
    maj_s   = swap ? a1 : a0;
    maj_e   = swap ? a0 : a1;
    min_s   = swap ? b1 : b0;
    min_e   = swap ? b0 : b1;
    dmaj    = $signed({maj_e[CoordW-1], maj_e}) - $signed({maj_s[CoordW-1], maj_s});
    dmin    = $signed({min_e[CoordW-1], min_e}) - $signed({min_s[CoordW-1], min_s});
    ndmin   = -dmin;
    admin   = dmin[DW-1] ? ndmin[CoordW-1:0] : dmin[CoordW-1:0];
    err0    = $signed({2'b00, admin, 1'b0}) - $signed({3'b000, dmaj[CoordW-1:0]});
  end

  always_comb begin
    err_pos    = !err_q[EW-1] && (err_q != '0);
    inc_b      = $signed({2'b00, mind_q, 1'b0});
    inc_a      = inc_b - $signed({2'b00, majd_q, 1'b0});
    err_next   = err_q + (err_pos ? inc_a : inc_b);
    minor_move = err_pos;
    major_ext1 = $signed({major_q[CoordW-1], major_q}) + $signed({{(DW-1){1'b0}}, 1'b1});
    end_ext    = $signed({end_q[CoordW-1], end_q});
    last       = (major_ext1 >= end_ext);
    raw_x      = steep_q ? minor_q : major_q;
    raw_y      = steep_q ? major_q : minor_q;
    x_inc      = steep_q ? (minor_move && !minor_neg_q) : 1'b1;
    x_dec      = steep_q ? (minor_move && minor_neg_q)  : 1'b0;
    y_inc      = steep_q ? 1'b1 : (minor_move && !minor_neg_q);
    y_dec      = steep_q ? 1'b0 : (minor_move && minor_neg_q);
  end

  bres_mod #(.CoordW(CoordW)) u_mod_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.wrap_start),
    .value_i (raw_x),
    .size_i  (eff_w),
    .done_o  (done_x),
    .rem_o   (mod_x)
  );

  bres_mod #(.CoordW(CoordW)) u_mod_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.wrap_start),
    .value_i (raw_y),
    .size_i  (eff_h),
    .done_o  (done_y),
    .rem_o   (mod_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_w_q    <= bres_pkg::VIEW_W_RESET;
      view_h_q    <= bres_pkg::VIEW_H_RESET;
      active_q    <= 1'b0;
      stale_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (bres_pkg::reg_idx_e'(cfg_index_i))
          bres_pkg::REG_VIEW_WIDTH:  view_w_q <= cfg_data_i;
          bres_pkg::REG_VIEW_HEIGHT: view_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load_line) begin
        active_q <= (maj_s != maj_e);
      end else if (cmd_i.emit && last) begin
        active_q <= 1'b0;
      end
      if (cfg_valid_i || cmd_i.load_line) begin
        stale_q <= 1'b1;
      end else if (done_x && done_y) begin
        stale_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_line) begin
      steep_q     <= steep_n;
      major_q     <= maj_s;
      end_q       <= maj_e;
      minor_q     <= min_s;
      minor_neg_q <= dmin[DW-1];
      majd_q      <= dmaj[CoordW-1:0];
      mind_q      <= admin;
      err_q       <= err0;
      color_q     <= line_color_i;
    end else if (cmd_i.emit) begin
      major_q <= major_q + $signed({{(CoordW-1){1'b0}}, 1'b1});
      if (minor_move) begin
        minor_q <= minor_neg_q ? minor_q - $signed({{(CoordW-1){1'b0}}, 1'b1})
                               : minor_q + $signed({{(CoordW-1){1'b0}}, 1'b1});
      end
      err_q <= err_next;
    end
    if (done_x && done_y) begin
      wx_q <= mod_x;
      wy_q <= mod_y;
    end else if (cmd_i.emit) begin
      wx_q <= bres_pkg::wrap_step(wx_q, eff_w, x_inc, x_dec);
      wy_q <= bres_pkg::wrap_step(wy_q, eff_h, y_inc, y_dec);
    end
    if (cmd_i.emit) begin
      out_x_q     <= wx_q;
      out_y_q     <= wy_q;
      out_color_q <= color_q;
      out_last_q  <= last;
    end
  end

  assign status_o.line_active = active_q;
  assign status_o.wrap_stale  = stale_q;
  assign status_o.wrap_done   = done_x && done_y;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign pixel_color_o = out_color_q;
  assign last_pixel_o  = out_last_q;

endmodule

`default_nettype wire

>>> hdl/bres_ctrl.sv
// Controller state machine of the line rasterizer: accepts items and sequences
// the wrap unit and the pixel output. Depends on bres_pkg.
`default_nettype none

module bres_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire bres_pkg::opcode_e    opcode_i,
  output logic                      in_ready_o,
  input  wire bres_pkg::dp_status_t status_i,
  output bres_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WRAP = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          if (opcode_i == bres_pkg::OP_START) begin
            cmd_o.load_line = 1'b1;
          end else if (status_i.line_active) begin
            if (status_i.wrap_stale) begin
              cmd_o.wrap_start = 1'b1;
              state_d          = ST_WRAP;
            end else begin
              cmd_o.emit = 1'b1;
            end
          end
        end
      end
      ST_WRAP: begin
        if (status_i.wrap_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bresenham_line_wrapped.sv
// Top level of the wrapped Bresenham line rasterizer; depends on bres_pkg, bres_ctrl, bres_dp.
// A start item emits nothing. A step item has its pixel on the output in the cycle after its
// transfer, a pixel per cycle while the wrapped position is current and the output is free.
// After a start item or a view write, the next step first runs the bit-serial modulo, and its
// pixel is registered once the modulo ends and the output is free. Reset: asynchronous, active
// low; the line is idle, the view is 640 by 480 and the output register is empty.
`default_nettype none

module bresenham_line_wrapped #(
  parameter int unsigned COORD_WIDTH = bres_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // Fields from bit 0 up: start_x, start_y, end_x, end_y, line_color, zero fill.
  input  wire logic [((4*COORD_WIDTH+bres_pkg::COLOR_W+7)/8)*8-1:0] s_axis_tdata,
  // Fields from bit 0 up: opcode.
  input  wire logic                                  s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // Fields from bit 0 up: pixel_x, pixel_y, pixel_color.
  output logic [bres_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
  output logic                                       m_axis_tlast,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic                                  cfg_index_i,
  input  wire logic [bres_pkg::CFG_W-1:0]            cfg_data_i
);

  localparam int unsigned CW = COORD_WIDTH;

  bres_pkg::ctrl_cmd_t           cmd;
  bres_pkg::dp_status_t          status;
  logic [bres_pkg::PIX_W-1:0]    pixel_x, pixel_y;
  logic [bres_pkg::COLOR_W-1:0]  pixel_color;

  bres_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (bres_pkg::opcode_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bres_dp #(.CoordW(CW)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .start_x_i     ($signed(s_axis_tdata[CW-1:0])),
    .start_y_i     ($signed(s_axis_tdata[2*CW-1:CW])),
    .end_x_i       ($signed(s_axis_tdata[3*CW-1:2*CW])),
    .end_y_i       ($signed(s_axis_tdata[4*CW-1:3*CW])),
    .line_color_i  (s_axis_tdata[4*CW+bres_pkg::COLOR_W-1:4*CW]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_pixel_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {pixel_color, pixel_y, pixel_x};
  assign cfg_ready_o  = 1'b1;

endmodule

`default_nettype wire

>>> verif/bresenham_line_wrapped_tb.sv
`timescale 1ns / 1ps
// Testbench of the wrapped Bresenham line rasterizer: a directed set of lines, then random
// lines under three idle patterns, each pixel checked against a scoreboard with its own predictor.
// Depends on bres_pkg and bresenham_line_wrapped.

import bres_pkg::*;

class pixel_scoreboard;
  int unsigned view_w;
  int unsigned view_h;
  bit line_on;
  bit steep;
  bit minor_down;
  int major_at;
  int major_stop;
  int minor_at;
  int major_span;
  int minor_span;
  int err_term;
  logic [COLOR_W-1:0] color;
  logic [2*PIX_W+COLOR_W:0] pixels_due[$];
  int mismatches;

  function new();
    view_w = 32'(VIEW_W_RESET);
    view_h = 32'(VIEW_H_RESET);
    line_on = 1'b0;
    steep = 1'b0;
    minor_down = 1'b0;
    major_at = 0;
    major_stop = 0;
    minor_at = 0;
    major_span = 0;
    minor_span = 0;
    err_term = 0;
    color = '0;
    mismatches = 0;
  endfunction

  function void set_view(reg_idx_e idx, logic [CFG_W-1:0] v);
    if (idx == REG_VIEW_WIDTH) begin
      view_w = 32'(v);
    end else begin
      view_h = 32'(v);
    end
  endfunction

  function int pending();
    return pixels_due.size();
  endfunction

  function int coord(logic [COORD_WIDTH_DEF-1:0] v);
    return int'($signed(v));
  endfunction

  function int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function int wrap(int v, int unsigned size);
    int w;
    int r;
    w = (size < 1) ? 1 : ((size > 4096) ? 4096 : int'(size));
    r = v % w;
    if (r < 0) begin
      r += w;
    end
    return r;
  endfunction

  // Returns 1 for a start or for a step that produces a pixel.
  function bit note_item(opcode_e op,
                         logic [((4*COORD_WIDTH_DEF+COLOR_W+7)/8)*8-1:0] d);
    int x0, y0, x1, y1, a0, a1, b0, b1, t;
    int px, py;
    bit fin;
    logic [PIX_W-1:0] wx, wy;
    if (op == OP_START) begin
      x0 = coord(d[0 +: COORD_WIDTH_DEF]);
      y0 = coord(d[COORD_WIDTH_DEF +: COORD_WIDTH_DEF]);
      x1 = coord(d[2*COORD_WIDTH_DEF +: COORD_WIDTH_DEF]);
      y1 = coord(d[3*COORD_WIDTH_DEF +: COORD_WIDTH_DEF]);
      steep = !(mag(y1 - y0) < mag(x1 - x0));
      if (steep) begin
        a0 = y0; a1 = y1; b0 = x0; b1 = x1;
      end else begin
        a0 = x0; a1 = x1; b0 = y0; b1 = y1;
      end
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      minor_down = (b1 - b0) < 0;
      minor_span = mag(b1 - b0);
      major_span = a1 - a0;
      major_at = a0;
      major_stop = a1;
      minor_at = b0;
      err_term = 2 * minor_span - major_span;
      color = d[4*COORD_WIDTH_DEF +: COLOR_W];
      line_on = a0 < a1;
      return 1'b1;
    end
    if (!line_on) begin
      return 1'b0;
    end
    px = steep ? minor_at : major_at;
    py = steep ? major_at : minor_at;
    fin = (major_at + 1) >= major_stop;
    wx = PIX_W'(wrap(px, view_w));
    wy = PIX_W'(wrap(py, view_h));
    pixels_due.push_back({fin, color, wy, wx});
    if (err_term > 0) begin
      minor_at += minor_down ? -1 : 1;
      err_term += 2 * (minor_span - major_span);
    end else begin
      err_term += 2 * minor_span;
    end
    major_at++;
    if (fin) begin
      line_on = 1'b0;
    end
    return 1'b1;
  endfunction

  task report(string what);
    $display("%0t ns pixel check: %s", $time, what);
    mismatches++;
  endtask

  task check_pixel(logic [OUT_TDATA_W-1:0] d, logic fin);
    logic [2*PIX_W+COLOR_W:0] e;
    if (pixels_due.size() == 0) begin
      report($sformatf("pixel x=%0d y=%0d with none pending", d[PIX_W-1:0],
                       d[2*PIX_W-1:PIX_W]));
      return;
    end
    e = pixels_due.pop_front();
    if (d[PIX_W-1:0] != e[PIX_W-1:0]) begin
      report($sformatf("x got %0d wanted %0d", d[PIX_W-1:0], e[PIX_W-1:0]));
    end
    if (d[2*PIX_W-1:PIX_W] != e[2*PIX_W-1:PIX_W]) begin
      report($sformatf("y got %0d wanted %0d", d[2*PIX_W-1:PIX_W], e[2*PIX_W-1:PIX_W]));
    end
    if (d[OUT_TDATA_W-1:2*PIX_W] != e[OUT_TDATA_W-1:2*PIX_W]) begin
      report($sformatf("color got %h wanted %h", d[OUT_TDATA_W-1:2*PIX_W],
                       e[OUT_TDATA_W-1:2*PIX_W]));
    end
    if (fin != e[OUT_TDATA_W]) begin
      report($sformatf("last flag got %0b wanted %0b", fin, e[OUT_TDATA_W]));
    end
  endtask
endclass

module bresenham_line_wrapped_tb;
  localparam int CW = COORD_WIDTH_DEF;
  localparam int IN_W = ((4*CW+COLOR_W+7)/8)*8;
  localparam int HOLD_OFF = CW + 6;
  localparam int STALL_LIMIT = 5000;
  localparam int COORD_MIN = -(1 << (CW-1));
  localparam int COORD_MAX = (1 << (CW-1)) - 1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_index_i = 1'b0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  int src_idle = 0;
  int dst_idle = 0;
  int idle_cycles = 0;
  int counted = 0;
  pixel_scoreboard raster;

  bresenham_line_wrapped i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      raster.check_pixel(m_axis_tdata, m_axis_tlast);
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= dst_idle);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [IN_W-1:0] noise();
    return IN_W'({$urandom, $urandom, $urandom});
  endfunction

  function automatic int rnd_coord();
    return int'($urandom_range(0, 2*COORD_MAX + 1)) + COORD_MIN;
  endfunction

  task automatic push_item(opcode_e op, logic [IN_W-1:0] d);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    if (raster.note_item(op, d)) begin
      counted++;
    end
  endtask

  // The sender holds off until every pixel has arrived and the block has gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (raster.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (HOLD_OFF) @(posedge clk_i);
  endtask

  task automatic write_view(reg_idx_e idx, int v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(v);
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    raster.set_view(idx, CFG_W'(v));
  endtask

  task automatic send_segment(int x0, int y0, int x1, int y1, int steps,
                              logic [COLOR_W-1:0] c);
    logic [IN_W-1:0] d;
    d = '0;
    d[0 +: CW]      = CW'(x0);
    d[CW +: CW]     = CW'(y0);
    d[2*CW +: CW]   = CW'(x1);
    d[3*CW +: CW]   = CW'(y1);
    d[4*CW +: COLOR_W] = c;
    push_item(OP_START, d);
    repeat (steps) push_item(OP_STEP, noise());
  endtask

  task automatic random_line();
    int x0, y0, x1, y1, dx, dy, reach, len, steps;
    reach = ($urandom_range(0, 9) == 0) ? 60 : 12;
    if ($urandom_range(0, 1) != 0) begin
      x0 = rnd_coord();
      y0 = rnd_coord();
    end else begin
      x0 = int'($urandom_range(0, 80)) - 40;
      y0 = int'($urandom_range(0, 80)) - 40;
    end
    dx = int'($urandom_range(0, 2*reach)) - reach;
    dy = int'($urandom_range(0, 2*reach)) - reach;
    x1 = x0 + dx;
    y1 = y0 + dy;
    if (x1 > COORD_MAX || x1 < COORD_MIN) begin
      x1 = x0 - dx;
    end
    if (y1 > COORD_MAX || y1 < COORD_MIN) begin
      y1 = y0 - dy;
    end
    len = raster.mag(x1 - x0) > raster.mag(y1 - y0) ? raster.mag(x1 - x0)
                                                    : raster.mag(y1 - y0);
    if ($urandom_range(0, 19) == 0) begin
      x1 = rnd_coord();
      y1 = rnd_coord();
      steps = $urandom_range(1, 12);
    end else if ($urandom_range(0, 6) == 0) begin
      steps = $urandom_range(0, len);
    end else begin
      steps = len + int'($urandom_range(0, 1));
    end
    send_segment(x0, y0, x1, y1, steps, $urandom);
  endtask

  function automatic int random_view();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1);
      1: return $urandom_range(4096, 8191);
      default: return $urandom_range(1, 100);
    endcase
  endfunction

  initial begin
    raster = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(OP_STEP, noise());
    send_segment(7, 7, 7, 7, 1, 32'h0000_0000);
    send_segment(COORD_MAX, COORD_MIN, COORD_MAX - 2, COORD_MIN + 1, 2, 32'hFFFF_FFFF);
    send_segment(COORD_MIN, COORD_MAX, COORD_MIN + 1, COORD_MAX - 3, 1, 32'h5A5A_A5A5);
    send_segment(0, 0, -2, 2, 2, 32'hA5A5_5A5A);
    send_segment(-1, -1, 0, 0, 1, 32'h0000_0001);
    write_view(REG_VIEW_WIDTH, 0);
    write_view(REG_VIEW_HEIGHT, 8191);
    send_segment(5, -5, 8, -4, 3, 32'h8000_0000);
    write_view(REG_VIEW_WIDTH, int'(VIEW_MAX));
    write_view(REG_VIEW_HEIGHT, 1);
    send_segment(4095, 4096, 4097, 4098, 2, 32'h7FFF_FFFE);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle = 16;
          dst_idle = 81;
          write_view(REG_VIEW_WIDTH, $urandom_range(1, 64));
          write_view(REG_VIEW_HEIGHT, $urandom_range(1, 64));
        end
        1: begin
          src_idle = 81;
          dst_idle = 16;
          write_view(REG_VIEW_WIDTH, $urandom_range(1, 4096));
          write_view(REG_VIEW_HEIGHT, $urandom_range(1, 300));
        end
        default: begin
          src_idle = 0;
          dst_idle = 0;
          write_view(REG_VIEW_WIDTH, $urandom_range(0, 8191));
          write_view(REG_VIEW_HEIGHT, $urandom_range(0, 8191));
        end
      endcase
      counted = 0;
      while (counted < 300) begin
        if ($urandom_range(0, 49) == 0) begin
          if ($urandom_range(0, 1) != 0) begin
            write_view(REG_VIEW_WIDTH, random_view());
          end else begin
            write_view(REG_VIEW_HEIGHT, random_view());
          end
        end else if ($urandom_range(0, 9) == 0) begin
          push_item(($urandom_range(0, 1) != 0) ? OP_STEP : OP_START, noise());
        end else begin
          random_line();
        end
      end
    end

    settle();
    if (raster.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
